// ===== rtl/core/srb_pkg.sv =====
// Shared types, constants and saturation helpers for the struck resonator bank.
package srb_pkg;

  localparam int STATE_WIDTH     = 32;
  localparam int FRAC_BITS       = 20;
  localparam int COEFS           = 8;
  localparam int SEL_W           = 3;
  localparam int OSCILLATORS_DEF = 16;
  localparam int OPW             = STATE_WIDTH + 1;
  localparam int OUT_W           = 24;
  localparam int CFG_W           = 22;

  localparam int MUL_DIG   = 17;
  localparam int MUL_STEPS = 2;
  localparam int DIV_BITS  = STATE_WIDTH + FRAC_BITS;
  localparam int DIV_PER   = 2;
  localparam int DIV_ITERS = DIV_BITS / DIV_PER;

  localparam logic [6:0]  LOWEST_RESET = 7'd0;
  localparam logic [21:0] GAIN_RESET   = 22'd1048576;
  localparam logic [15:0] LFSR_SEED    = 16'hACE1;

  localparam logic signed [63:0] ONE_Q  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -(64'sd1 <<< (STATE_WIDTH - 1));
  localparam logic [63:0]        MAG_LIM = 64'd1 << (STATE_WIDTH - 1);

  localparam logic [1:0] CMD_NOTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_COEF = 2'd2;

  localparam logic [SEL_W-1:0] SEL_DECAY = 3'd0;
  localparam logic [SEL_W-1:0] SEL_TUNE  = 3'd1;
  localparam logic [SEL_W-1:0] SEL_GAIN  = 3'd2;
  localparam logic [SEL_W-1:0] SEL_NOISE = 3'd3;
  localparam logic [SEL_W-1:0] SEL_DIST1 = 3'd4;
  localparam logic [SEL_W-1:0] SEL_DIST2 = 3'd5;
  localparam logic [SEL_W-1:0] SEL_LEFT  = 3'd6;
  localparam logic [SEL_W-1:0] SEL_RIGHT = 3'd7;

  localparam logic REG_LOWEST = 1'b0;
  localparam logic REG_GAIN   = 1'b1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [6:0]        note;
    logic [6:0]        velocity;
    logic [3:0]        osc_index;
    logic [2:0]        coef_select;
    logic signed [31:0] coef_value;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] left_sample;
    logic signed [OUT_W-1:0] right_sample;
  } out_t;

  typedef struct packed {
    logic signed [STATE_WIDTH-1:0] pending;
    logic signed [STATE_WIDTH-1:0] x1;
    logic signed [STATE_WIDTH-1:0] x2;
    logic signed [STATE_WIDTH-1:0] y1;
    logic signed [STATE_WIDTH-1:0] y2;
  } row_t;

  typedef struct packed {
    logic                  start;
    logic signed [OPW-1:0] a;
    logic signed [OPW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                          start;
    logic signed [STATE_WIDTH-1:0] num;
    logic signed [STATE_WIDTH-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                          done;
    logic signed [STATE_WIDTH-1:0] value;
  } unit_rsp_t;

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [63:0] v);
    logic signed [STATE_WIDTH-1:0] r;
    if (v > SAT_HI) r = SAT_HI[STATE_WIDTH-1:0];
    else if (v < SAT_LO) r = SAT_LO[STATE_WIDTH-1:0];
    else r = v[STATE_WIDTH-1:0];
    return r;
  endfunction

  function automatic logic signed [STATE_WIDTH-1:0] sat_mag(input logic neg,
                                                            input logic [63:0] mag);
    logic [63:0] m;
    logic [63:0] s;
    if (neg) begin
      m = (mag > MAG_LIM) ? MAG_LIM : mag;
      s = ~m + 64'd1;
    end else begin
      s = (mag > MAG_LIM - 64'd1) ? MAG_LIM - 64'd1 : mag;
    end
    return s[STATE_WIDTH-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(input logic signed [STATE_WIDTH-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > STATE_WIDTH'(8388607)) r = 24'sd8388607;
    else if (v < -STATE_WIDTH'(8388608)) r = -24'sd8388608;
    else r = v[OUT_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/srb_mul.sv =====
// Multi-cycle Q.20 multiplier with truncation and saturation, one digit per cycle.
module srb_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  srb_pkg::mul_req_t   req,
  output srb_pkg::unit_rsp_t  rsp
);

  localparam int OPW = srb_pkg::OPW;
  localparam int DIG = srb_pkg::MUL_DIG;
  localparam int UBW = DIG * srb_pkg::MUL_STEPS;
  localparam int PW  = OPW + UBW;
  localparam int CW  = (srb_pkg::MUL_STEPS > 1) ? $clog2(srb_pkg::MUL_STEPS) : 1;
  localparam logic [CW-1:0] LAST = CW'(srb_pkg::MUL_STEPS - 1);

  logic                busy_r;
  logic                done_r;
  logic [CW-1:0]       cnt_r;
  logic [OPW-1:0]      ua_r;
  logic [UBW-1:0]      ub_r;
  logic                neg_r;
  logic [PW-1:0]       acc_r;
  logic signed [srb_pkg::STATE_WIDTH-1:0] res_r;

  logic [OPW-1:0]     ua_in;
  logic [OPW-1:0]     ub_in;
  logic [DIG-1:0]     digit;
  logic [OPW+DIG-1:0] pp;
  logic [PW-1:0]      acc_nxt;
  logic [63:0]        mag;

  always_comb begin
    ua_in   = req.a[OPW-1] ? (~req.a + 1'b1) : req.a;
    ub_in   = req.b[OPW-1] ? (~req.b + 1'b1) : req.b;
    digit   = ub_r[UBW-1 -: DIG];
    pp      = ua_r * digit;
    acc_nxt = (acc_r << DIG) + PW'(pp);
    mag     = 64'(acc_nxt[PW-1:srb_pkg::FRAC_BITS]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        ua_r   <= ua_in;
        ub_r   <= UBW'(ub_in);
        neg_r  <= req.a[OPW-1] ^ req.b[OPW-1];
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        ub_r  <= ub_r << DIG;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= srb_pkg::sat_mag(neg_r, mag);
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

// ===== rtl/core/srb_div.sv =====
// Restoring Q.20 divider, two quotient bits per cycle, saturated result.
module srb_div (
  input  logic                clk,
  input  logic                rst_n,
  input  srb_pkg::div_req_t   req,
  output srb_pkg::unit_rsp_t  rsp
);

  localparam int W   = srb_pkg::STATE_WIDTH;
  localparam int NB  = srb_pkg::DIV_BITS;
  localparam int PER = srb_pkg::DIV_PER;
  localparam int CW  = $clog2(srb_pkg::DIV_ITERS);
  localparam logic [CW-1:0] LAST = CW'(srb_pkg::DIV_ITERS - 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NB-1:0] n_r;
  logic [W-1:0]  d_r;
  logic [W-1:0]  r_r;
  logic [NB-1:0] q_r;
  logic          neg_r;
  logic signed [W-1:0] res_r;

  logic [W-1:0]  nmag;
  logic [W-1:0]  dmag;
  logic [NB-1:0] n_nxt;
  logic [W-1:0]  r_nxt;
  logic [NB-1:0] q_nxt;
  logic [W:0]    rs;
  logic          ge;

  always_comb begin
    nmag  = req.num[W-1] ? (~req.num + 1'b1) : req.num;
    dmag  = req.den[W-1] ? (~req.den + 1'b1) : req.den;
    n_nxt = n_r;
    r_nxt = r_r;
    q_nxt = q_r;
    for (int i = 0; i < PER; i++) begin
      rs    = {r_nxt, n_nxt[NB-1]};
      n_nxt = n_nxt << 1;
      ge    = (rs >= {1'b0, d_r});
      r_nxt = ge ? W'(rs - {1'b0, d_r}) : rs[W-1:0];
      q_nxt = {q_nxt[NB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.den == '0) begin
          // A zero denominator gives a zero shaped value.
          res_r  <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          n_r    <= {nmag, srb_pkg::FRAC_BITS'(0)};
          d_r    <= dmag;
          r_r    <= '0;
          q_r    <= '0;
          neg_r  <= req.num[W-1] ^ req.den[W-1];
        end
      end else if (busy_r) begin
        n_r   <= n_nxt;
        r_r   <= r_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= srb_pkg::sat_mag(neg_r, 64'(q_nxt));
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

// ===== rtl/core/struck_resonator_bank_synth.sv =====
// Top level: sequencer, coefficient and state memories, shared multiplier and divider.
//
//   port group | direction | carries
//   in_*       | input     | note-on, sample tick or coefficient write request
//   out_*      | output    | one stereo sample per sample tick
//   cfg_*      | input     | lowest note and master gain register writes
//
// A note-on passes through the note state before the next request is taken; a coefficient
// write is done in the cycle it is accepted. A sample tick runs, per oscillator, nine
// products on the shared multiplier and one division, then two output gain products.
// After reset a clearing pass over all OSCILLATORS * 8 coefficient addresses zeroes both memories;
// no request is taken meanwhile, register writes are.
// A finished sample waits in the output register; a tick that completes while it
// is still held stalls until it is taken.
module struck_resonator_bank_synth #(
  parameter int OSCILLATORS = srb_pkg::OSCILLATORS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  srb_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output srb_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [srb_pkg::CFG_W-1:0]     cfg_data
);

  localparam int W     = srb_pkg::STATE_WIDTH;
  localparam int OPW   = srb_pkg::OPW;
  localparam int OW    = (OSCILLATORS > 1) ? $clog2(OSCILLATORS) : 1;
  localparam int CAW   = OW + srb_pkg::SEL_W;
  localparam int NCOEF = OSCILLATORS * srb_pkg::COEFS;
  localparam int ACCW  = W + OW + 1;
  localparam logic [OW-1:0]  LAST_OSC = OW'(OSCILLATORS - 1);
  localparam logic [CAW-1:0] LAST_CLR = CAW'(NCOEF - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_NOTE  = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic [3:0] STEP_DECAY = 4'd0;
  localparam logic [3:0] STEP_TUNE  = 4'd1;
  localparam logic [3:0] STEP_BAND  = 4'd2;
  localparam logic [3:0] STEP_NOISE = 4'd3;
  localparam logic [3:0] STEP_MOD   = 4'd4;
  localparam logic [3:0] STEP_SQR   = 4'd5;
  localparam logic [3:0] STEP_DIST1 = 4'd6;
  localparam logic [3:0] STEP_DIST2 = 4'd7;
  localparam logic [3:0] STEP_DIV   = 4'd8;
  localparam logic [3:0] STEP_LEFT  = 4'd9;
  localparam logic [3:0] STEP_RIGHT = 4'd10;
  localparam logic [3:0] STEP_OUTL  = 4'd11;
  localparam logic [3:0] STEP_OUTR  = 4'd12;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [OW-1:0] osc_r, osc_nxt;
  logic [6:0]  vel_r, vel_nxt;
  logic [15:0] lfsr_r, lfsr_nxt;
  logic [6:0]  lowest_r;
  logic [21:0] gain_r;
  logic [CAW-1:0] clr_r;
  logic signed [OPW-1:0] t1_r, t1_nxt;
  logic signed [W-1:0] t2_r, t2_nxt;
  logic signed [W-1:0] y_r, y_nxt;
  logic signed [W-1:0] o_r, o_nxt;
  logic signed [ACCW-1:0] accl_r, accl_nxt;
  logic signed [ACCW-1:0] accr_r, accr_nxt;
  logic signed [srb_pkg::OUT_W-1:0] left_r, left_nxt;
  logic signed [srb_pkg::OUT_W-1:0] right_r, right_nxt;
  logic          out_valid_r, out_valid_nxt;
  srb_pkg::out_t out_data_r, out_data_nxt;

  logic signed [31:0] coef_mem [NCOEF];
  logic signed [31:0] coef_q_r;
  srb_pkg::row_t      row_mem [OSCILLATORS];
  srb_pkg::row_t      row_q_r;

  logic               coef_we;
  logic [CAW-1:0]     coef_wa;
  logic signed [31:0] coef_wd;
  logic [CAW-1:0]     coef_ra;
  logic [srb_pkg::SEL_W-1:0] sel_nxt;
  logic               row_we;
  logic [OW-1:0]      row_wa;
  srb_pkg::row_t      row_wd;

  srb_pkg::mul_req_t  mul_req;
  srb_pkg::unit_rsp_t mul_rsp;
  srb_pkg::div_req_t  div_req;
  srb_pkg::unit_rsp_t div_rsp;

  logic        accept;
  logic        unit_done;
  logic [6:0]  diff;
  logic        note_ok;
  logic        osc_ok;
  logic        fb;
  logic signed [20:0] noise;
  logic signed [39:0] prod;
  logic signed [39:0] add;

  srb_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  srb_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    accept    = in_valid && in_ready;
    unit_done = (step_r == STEP_DIV) ? div_rsp.done : mul_rsp.done;
    diff      = in_data.note - lowest_r;
    note_ok   = (in_data.velocity != 7'd0) && (in_data.note >= lowest_r) &&
                (32'(diff) < OSCILLATORS);
    osc_ok    = 32'(in_data.osc_index) < OSCILLATORS;
    fb        = lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5];
    // (lfsr - 32768) * 32 in Q.20.
    noise     = $signed({~lfsr_r[15], lfsr_r[14:0], 5'b00000});
    prod      = 40'(coef_q_r) * 40'($signed({1'b0, vel_r}));
    // Division by 128 truncates toward zero.
    add       = prod[39] ? ((prod + 40'sd127) >>> 7) : (prod >>> 7);
  end

  // Operand selection for the shared multiplier and the divider.
  always_comb begin
    mul_req.start = (state_r == ST_RUN) && (step_r != STEP_BAND) && (step_r != STEP_DIV);
    case (step_r)
      STEP_DECAY: begin
        mul_req.a = OPW'(coef_q_r);
        mul_req.b = OPW'(row_q_r.pending) - OPW'(row_q_r.y2);
      end
      STEP_TUNE: begin
        mul_req.a = OPW'(coef_q_r);
        mul_req.b = OPW'(row_q_r.x1) - OPW'(row_q_r.y1);
      end
      STEP_NOISE: begin
        mul_req.a = OPW'(coef_q_r);
        mul_req.b = OPW'(noise);
      end
      STEP_MOD: begin
        mul_req.a = OPW'(o_r);
        mul_req.b = t1_r;
      end
      STEP_SQR: begin
        mul_req.a = OPW'(o_r);
        mul_req.b = OPW'(o_r);
      end
      STEP_DIST1: begin
        mul_req.a = OPW'(coef_q_r);
        mul_req.b = t1_r;
      end
      STEP_DIST2: begin
        mul_req.a = OPW'(o_r);
        mul_req.b = OPW'(coef_q_r);
      end
      STEP_OUTL: begin
        mul_req.a = OPW'(srb_pkg::sat_state(64'(accl_r)));
        mul_req.b = OPW'($signed({1'b0, gain_r}));
      end
      STEP_OUTR: begin
        mul_req.a = OPW'(srb_pkg::sat_state(64'(accr_r)));
        mul_req.b = OPW'($signed({1'b0, gain_r}));
      end
      default: begin
        mul_req.a = OPW'(coef_q_r);
        mul_req.b = OPW'(o_r);
      end
    endcase
    div_req.start = (state_r == ST_RUN) && (step_r == STEP_DIV);
    div_req.num   = t2_r;
    div_req.den   = t1_r[W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    osc_nxt       = osc_r;
    vel_nxt       = vel_r;
    lfsr_nxt      = lfsr_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    y_nxt         = y_r;
    o_nxt         = o_r;
    accl_nxt      = accl_r;
    accr_nxt      = accr_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    coef_we       = 1'b0;
    coef_wa       = clr_r;
    coef_wd       = '0;
    row_we        = 1'b0;
    row_wa        = osc_r;
    row_wd        = row_q_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        coef_we = 1'b1;
        row_we  = 1'b1;
        row_wa  = clr_r[CAW-1:srb_pkg::SEL_W];
        row_wd  = '0;
        if (clr_r == LAST_CLR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            srb_pkg::CMD_NOTE: begin
              if (note_ok) begin
                osc_nxt   = OW'(diff);
                vel_nxt   = in_data.velocity;
                state_nxt = ST_NOTE;
              end
            end
            srb_pkg::CMD_TICK: begin
              lfsr_nxt  = {fb, lfsr_r[15:1]};
              accl_nxt  = '0;
              accr_nxt  = '0;
              osc_nxt   = '0;
              step_nxt  = STEP_DECAY;
              state_nxt = ST_RUN;
            end
            srb_pkg::CMD_COEF: begin
              if (osc_ok) begin
                coef_we = 1'b1;
                coef_wa = {OW'(in_data.osc_index), in_data.coef_select};
                coef_wd = in_data.coef_value;
              end
            end
            default: ;
          endcase
        end
      end
      ST_NOTE: begin
        row_we         = 1'b1;
        row_wd.pending = srb_pkg::sat_state(64'(row_q_r.pending) + 64'(add));
        state_nxt      = ST_IDLE;
      end
      ST_RUN: begin
        case (step_r)
          STEP_BAND: begin
            o_nxt     = srb_pkg::sat_state(64'(y_r) - 64'(row_q_r.pending));
            row_we    = 1'b1;
            row_wd.pending = '0;
            row_wd.x1 = row_q_r.pending;
            row_wd.x2 = row_q_r.x1;
            row_wd.y1 = y_r;
            row_wd.y2 = row_q_r.y1;
            step_nxt  = STEP_NOISE;
          end
          default: state_nxt = ST_WAIT;
        endcase
      end
      ST_WAIT: begin
        if (unit_done) begin
          state_nxt = ST_RUN;
          step_nxt  = step_r + 4'd1;
          case (step_r)
            STEP_DECAY: t1_nxt = OPW'(mul_rsp.value);
            STEP_TUNE:  y_nxt  = srb_pkg::sat_state(64'(t1_r) + 64'(mul_rsp.value) +
                                                    64'(row_q_r.x2));
            STEP_NOISE: t1_nxt = OPW'(mul_rsp.value) + OPW'(srb_pkg::ONE_Q);
            STEP_MOD:   o_nxt  = mul_rsp.value;
            STEP_SQR:   t1_nxt = OPW'(mul_rsp.value);
            STEP_DIST1: t1_nxt = OPW'(srb_pkg::sat_state(64'(mul_rsp.value) + srb_pkg::ONE_Q));
            STEP_DIST2: t2_nxt = mul_rsp.value;
            STEP_DIV:   o_nxt  = div_rsp.value;
            STEP_LEFT:  accl_nxt = accl_r + ACCW'(mul_rsp.value);
            STEP_RIGHT: begin
              accr_nxt = accr_r + ACCW'(mul_rsp.value);
              if (osc_r == LAST_OSC) begin
                step_nxt = STEP_OUTL;
              end else begin
                osc_nxt  = osc_r + 1'b1;
                step_nxt = STEP_DECAY;
              end
            end
            STEP_OUTL: left_nxt = srb_pkg::clamp_out(mul_rsp.value);
            STEP_OUTR: begin
              right_nxt = srb_pkg::clamp_out(mul_rsp.value);
              state_nxt = ST_FIN;
            end
            default: ;
          endcase
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.left_sample  = left_r;
          out_data_nxt.right_sample = right_r;
          state_nxt                 = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Read addresses follow the next step so that the registered data lines up.
  always_comb begin
    if (state_nxt == ST_NOTE) begin
      sel_nxt = srb_pkg::SEL_GAIN;
    end else begin
      case (step_nxt)
        STEP_DECAY: sel_nxt = srb_pkg::SEL_DECAY;
        STEP_TUNE:  sel_nxt = srb_pkg::SEL_TUNE;
        STEP_NOISE: sel_nxt = srb_pkg::SEL_NOISE;
        STEP_DIST1: sel_nxt = srb_pkg::SEL_DIST1;
        STEP_DIST2: sel_nxt = srb_pkg::SEL_DIST2;
        STEP_LEFT:  sel_nxt = srb_pkg::SEL_LEFT;
        STEP_RIGHT: sel_nxt = srb_pkg::SEL_RIGHT;
        default:    sel_nxt = srb_pkg::SEL_DECAY;
      endcase
    end
    coef_ra = {osc_nxt, sel_nxt};
  end

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[coef_wa] <= coef_wd;
    coef_q_r <= coef_mem[coef_ra];
    if (row_we) row_mem[row_wa] <= row_wd;
    row_q_r <= row_mem[osc_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      step_r      <= STEP_DECAY;
      osc_r       <= '0;
      clr_r       <= '0;
      lfsr_r      <= srb_pkg::LFSR_SEED;
      lowest_r    <= srb_pkg::LOWEST_RESET;
      gain_r      <= srb_pkg::GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      osc_r       <= osc_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_we) begin
        case (cfg_index)
          srb_pkg::REG_LOWEST: lowest_r <= cfg_data[6:0];
          srb_pkg::REG_GAIN:   gain_r   <= cfg_data[21:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    vel_r      <= vel_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    y_r        <= y_nxt;
    o_r        <= o_nxt;
    accl_r     <= accl_nxt;
    accr_r     <= accr_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/srb_checker.sv =====
// Port-level checks for the struck resonator bank, bound to the top level.
module srb_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input srb_pkg::in_t              in_data,
  input logic                      out_valid,
  input logic                      out_ready,
  input srb_pkg::out_t             out_data
);

  // A held sample must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output sample changed while stalled");

  // A tick makes the block busy, so in_ready drops once the tick is taken.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.cmd == srb_pkg::CMD_TICK) |=> !in_ready)
    else $error("request taken right after a tick");

  // A sample never appears in the cycle after a request is taken.
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("sample appeared too early");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind struck_resonator_bank_synth srb_checker u_srb_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== tb/sv/struck_resonator_bank_synth_checker.sv =====
// Checker for the resonator bank: watches both channels, predicts samples and compares them.
module struck_resonator_bank_synth_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  srb_pkg::in_t               in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  srb_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [srb_pkg::CFG_W-1:0]  cfg_data,
  output int                         fail_count,
  output int                         samples_pending,
  output int                         samples_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import srb_pkg::*;

  localparam int NOSC = OSCILLATORS_DEF;
  localparam longint LIM = 64'sd1 <<< 31;

  longint strike [NOSC];
  longint xd1 [NOSC];
  longint xd2 [NOSC];
  longint yd1 [NOSC];
  longint yd2 [NOSC];
  longint coef [NOSC*COEFS];
  logic [15:0] lfsr;
  logic [6:0] base_note;
  logic [21:0] out_gain;
  out_t sample_q [$];

  function automatic longint clip(input bit neg, input logic [127:0] mag);
    if (neg) return (mag > LIM) ? -LIM : -longint'(mag[63:0]);
    return (mag > LIM - 1) ? LIM - 1 : longint'(mag[63:0]);
  endfunction

  function automatic logic [63:0] absval(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clip_sum(input longint v);
    return clip(v < 0, absval(v));
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    logic [127:0] p;
    p = absval(a) * absval(b);
    return clip((a < 0) != (b < 0), p >> FRAC_BITS);
  endfunction

  function automatic longint qdiv(input longint n, input longint d);
    logic [127:0] num, q;
    if (d == 0) return 0;
    num = {64'd0, absval(n)} << FRAC_BITS;
    q = num / absval(d);
    return clip((n < 0) != (d < 0), q);
  endfunction

  task automatic run_tick();
    longint noise, lsum, rsum, y, o, den, l, r;
    out_t s;
    lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
    noise = (longint'(lfsr) - 32768) * 32;
    lsum = 0;
    rsum = 0;
    for (int i = 0; i < NOSC; i++) begin
      y = clip_sum(qmul(coef[i*8], strike[i] - yd2[i]) +
                   qmul(coef[i*8+1], xd1[i] - yd1[i]) + xd2[i]);
      yd2[i] = yd1[i];
      yd1[i] = y;
      xd2[i] = xd1[i];
      xd1[i] = strike[i];
      o = clip_sum(y - strike[i]);
      o = qmul(o, (64'sd1 <<< FRAC_BITS) + qmul(coef[i*8+3], noise));
      den = clip_sum((64'sd1 <<< FRAC_BITS) + qmul(coef[i*8+4], qmul(o, o)));
      o = qdiv(qmul(o, coef[i*8+5]), den);
      lsum += qmul(coef[i*8+6], o);
      rsum += qmul(coef[i*8+7], o);
      strike[i] = 0;
    end
    l = qmul(clip_sum(lsum), longint'(out_gain));
    r = qmul(clip_sum(rsum), longint'(out_gain));
    if (l > 8388607) l = 8388607;
    if (l < -8388608) l = -8388608;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    s.left_sample = l[23:0];
    s.right_sample = r[23:0];
    sample_q.push_back(s);
  endtask

  task automatic apply_request(input in_t req);
    int k;
    if (req.cmd == CMD_NOTE) begin
      if (req.velocity != 0 && req.note >= base_note && req.note - base_note < NOSC) begin
        k = req.note - base_note;
        strike[k] = clip_sum(strike[k] + (coef[k*8+2] * longint'(req.velocity)) / 128);
      end
    end else if (req.cmd == CMD_COEF) begin
      coef[req.osc_index*8 + req.coef_select] = longint'(req.coef_value);
    end else if (req.cmd == CMD_TICK) begin
      run_tick();
    end
  endtask

  always @(posedge clk) begin
    out_t exp_s;
    if (!rst_n) begin
      for (int i = 0; i < NOSC; i++) begin
        strike[i] = 0; xd1[i] = 0; xd2[i] = 0; yd1[i] = 0; yd2[i] = 0;
      end
      for (int i = 0; i < NOSC*COEFS; i++) coef[i] = 0;
      lfsr = LFSR_SEED;
      base_note = LOWEST_RESET;
      out_gain = GAIN_RESET;
      sample_q.delete();
      fail_count = 0;
      samples_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_LOWEST) base_note = cfg_data[6:0];
        else out_gain = cfg_data;
      end
      if (out_valid && out_ready) begin
        samples_seen++;
        if (sample_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected sample %h", $time, out_data);
        end else begin
          exp_s = sample_q.pop_front();
          if (out_data.left_sample !== exp_s.left_sample) begin
            fail_count++;
            $display("%0t: left expected %0d actual %0d", $time,
                     exp_s.left_sample, out_data.left_sample);
          end
          if (out_data.right_sample !== exp_s.right_sample) begin
            fail_count++;
            $display("%0t: right expected %0d actual %0d", $time,
                     exp_s.right_sample, out_data.right_sample);
          end
        end
      end
      if (in_valid && in_ready) apply_request(in_data);
    end
    samples_pending = sample_q.size();
  end
endmodule

// ===== tb/sv/struck_resonator_bank_synth_tb.sv =====
// Top of the resonator bank testbench: clock, reset, stimulus, register writes and verdict.
module struck_resonator_bank_synth_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srb_pkg::*;

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready, cfg_we, cfg_index;
  in_t in_data;
  out_t out_data;
  logic [CFG_W-1:0] cfg_data;
  int fail_count, samples_pending, samples_seen;
  int idle_cycles;
  int requests_sent;
  bit hold_receiver;

  localparam int STALL_LIMIT = 20000;
  localparam int IN_W = $bits(in_t);

  struck_resonator_bank_synth uut (.*);

  struck_resonator_bank_synth_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls in a pattern; one long hold-off lets the block back up.
  initial begin
    int mode;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_receiver) out_ready <= 1'b0;
      else begin
        mode = $urandom_range(0, 9);
        out_ready <= (mode < 6) || (samples_seen % 50 > 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send(input in_t req);
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic pause_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    pause_input(1);
    while (samples_pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_t make_note(input logic [6:0] n, input logic [6:0] v);
    in_t r;
    r = IN_W'({$urandom, $urandom});
    r.cmd = CMD_NOTE;
    r.note = n;
    r.velocity = v;
    return r;
  endfunction

  function automatic in_t make_tick();
    in_t r;
    r = IN_W'({$urandom, $urandom});
    r.cmd = CMD_TICK;
    return r;
  endfunction

  function automatic in_t make_coef(input logic [3:0] o, input logic [2:0] s,
                                    input logic signed [31:0] v);
    in_t r;
    r = IN_W'({$urandom, $urandom});
    r.cmd = CMD_COEF;
    r.osc_index = o;
    r.coef_select = s;
    r.coef_value = v;
    return r;
  endfunction

  // Coefficients mostly in a musical range, sometimes at the extremes.
  function automatic logic signed [31:0] pick_coef(input logic [2:0] s);
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: begin
        if (s == SEL_DECAY) return 32'sd1900000 + $urandom_range(0, 190000);
        if (s == SEL_TUNE) return -32'sd1000000 - $urandom_range(0, 1000000);
        return $signed($urandom_range(0, 4194304)) - 32'sd2097152;
      end
    endcase
  endfunction

  task automatic random_phase(input int count, input logic [6:0] base);
    int burst;
    in_t r;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) r = make_note(base + 7'($urandom_range(0, 17)), 7'($urandom));
      else if (kind < 55) r = make_note(7'($urandom), 7'($urandom));
      else if (kind < 80) r = make_tick();
      else if (kind < 97) begin
        r = make_coef(4'($urandom), 3'($urandom), 0);
        r.coef_value = pick_coef(r.coef_select);
      end else begin
        r = IN_W'({$urandom, $urandom});
        r.cmd = 2'd3;
      end
      send(r);
      burst = $urandom_range(0, 15);
      if (burst < 3) pause_input($urandom_range(1, 40));
    end
  endtask

  initial begin
    in_t r;
    requests_sent = 0;
    hold_receiver = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_LOWEST;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a tick on the reset state, all coefficients of oscillator 0 and four of
    // oscillator 15, strikes in and out of the window, zero velocity, a skipped command.
    send(make_tick());
    for (int s = 0; s < 8; s++) send(make_coef(4'd0, 3'(s), pick_coef(3'(s))));
    send(make_coef(4'd15, SEL_GAIN, 32'sh7FFF_FFFF));
    send(make_coef(4'd15, SEL_DIST2, 32'sh8000_0000));
    send(make_coef(4'd15, SEL_LEFT, 32'sd1048576));
    send(make_coef(4'd15, SEL_DIST1, 32'sd0));
    send(make_note(7'd0, 7'd127));
    send(make_note(7'd15, 7'd127));
    send(make_note(7'd15, 7'd127));
    send(make_note(7'd16, 7'd127));
    send(make_note(7'd127, 7'd1));
    send(make_note(7'd0, 7'd0));
    r = '1;
    r.cmd = 2'd3;
    send(r);
    send(make_tick());
    send(make_tick());
    send(make_tick());
    drain();

    write_reg(REG_GAIN, 22'h3F_FFFF);
    write_reg(REG_LOWEST, 22'd127);
    send(make_note(7'd127, 7'd127));
    send(make_tick());
    drain();
    write_reg(REG_LOWEST, 22'd110);
    write_reg(REG_GAIN, 22'd0);
    random_phase(150, 7'd110);

    // The receiver holds off while requests keep coming, so the block backs up.
    hold_receiver = 1;
    fork
      random_phase(60, 7'd110);
      repeat (3000) @(posedge clk);
    join_any
    hold_receiver = 0;
    wait fork;
    drain();

    write_reg(REG_LOWEST, 22'd0);
    write_reg(REG_GAIN, 22'd2097152);
    random_phase(400, 7'd0);
    drain();
    write_reg(REG_LOWEST, CFG_W'($urandom_range(1, 100)));
    write_reg(REG_GAIN, 22'($urandom_range(0, 2097152)));
    random_phase(350, 7'd40);
    drain();

    $display("Sent %0d requests; checked %0d stereo samples across five register settings.",
             requests_sent, samples_seen);
    if (fail_count == 0 && samples_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/srb_pkg.sv
rtl/core/srb_mul.sv
rtl/core/srb_div.sv
rtl/core/struck_resonator_bank_synth.sv
rtl/core/srb_checker.sv
tb/sv/struck_resonator_bank_synth_checker.sv
tb/sv/struck_resonator_bank_synth_tb.sv
